// ----- src/grdda_pkg.sv -----
// ----------------------------------------------------------------------------
// grdda_pkg
// shared types and constants for the grid ray traversal core
// ----------------------------------------------------------------------------
package grdda_pkg;

    localparam int DEF_GRID_W    = 64;
    localparam int DEF_GRID_H    = 64;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [7:0]  VOXEL_RESET = 8'd16;
    localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic REG_VOXEL_W = 1'b0;
    localparam logic REG_VOXEL_H = 1'b1;

    // item kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_RAY   = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [5:0]         cell_x;
        logic [5:0]         cell_y;
        logic signed [7:0]  cell_value;
        logic [23:0]        origin_x;
        logic [23:0]        origin_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } in_word_t;

    typedef struct packed {
        logic [5:0] hit_x;
        logic [5:0] hit_y;
        logic       hit_side;
        logic       started_in_solid;
        logic       left_grid;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_PX,
        ST_DIV_PY,
        ST_SQRT,
        ST_DIV_SX,
        ST_DIV_SY,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_END,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

// ----- src/grid_ray_traversal_dda_core.sv -----
// ----------------------------------------------------------------------------
// grid_ray_traversal_dda_core
// 2d tile map ray walk (dda) over a solid/empty map held in block memory
// ----------------------------------------------------------------------------
// A map write word is written to the map as it is taken. A ray
// word runs on a single shared restoring divider and a digit-by-digit
// square root: two divides for the tile position, one root, two divides
// for the axis steps, then the intercept multiplies (ST_MUL_X, ST_MUL_Y,
// ST_MUL_END) and the hand-over of the result in ST_DONE, which waits while
// the output stalls. The walk then does one map read per tile visited
// (ST_READ then ST_CHECK), up to GRID_W+GRID_H-1 tiles. Only one word is in
// work at a time; a finished result sits in the output register while the
// next word is taken. After reset all GRID_W*GRID_H cells of the map are
// cleared one cell per cycle, during which no word is taken (configuration
// writes still are).
module grid_ray_traversal_dda_core #(
    parameter int GRID_W    = grdda_pkg::DEF_GRID_W,
    parameter int GRID_H    = grdda_pkg::DEF_GRID_H,
    parameter int FRAC_BITS = grdda_pkg::DEF_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  grdda_pkg::in_word_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output grdda_pkg::out_word_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data
);
    import grdda_pkg::*;

    localparam int DEPTH = GRID_W * GRID_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(GRID_W);
    localparam int YW    = $clog2(GRID_H);
    localparam int DW    = 24 + FRAC_BITS;
    localparam int PW    = 16 + FRAC_BITS;
    localparam int CW    = $clog2(DW + 1);
    localparam int MW    = FRAC_BITS + 33;

    state_t state_reg, state_next;

    logic [CW-1:0]  cnt_reg;
    logic [AW-1:0]  clr_reg;
    logic [7:0]     vw_reg, vh_reg;
    logic [23:0]    oy_reg;
    logic [15:0]    mx_reg, my_reg;
    logic           negx_reg, negy_reg;
    logic [DW-1:0]  dq_reg;
    logic [15:0]    drem_reg, dvs_reg;
    logic [PW-1:0]  px_reg, py_reg;
    logic [31:0]    sq_reg, root_reg;
    logic [34:0]    srem_reg;
    logic [31:0]    stepx_reg, stepy_reg, icx_reg, icy_reg;
    logic [MW-1:0]  prod_reg;
    logic [XW-1:0]  tx_reg;
    logic [YW-1:0]  ty_reg;
    logic           side_reg, first_reg;
    logic           map_rd_reg;
    out_word_t      res_reg, out_reg;
    logic           out_valid_reg;

    logic           mem [DEPTH];

    logic           in_acc, out_free;
    logic [7:0]     vw_eff, vh_eff;
    logic [16:0]    div_rem2;
    logic           div_ge;
    logic [16:0]    div_diff;
    logic [63:0]    dq_ext, len_ext;
    logic [31:0]    q_sat;
    logic [36:0]    s_rem2, s_trial;
    logic           s_ge;
    logic [15:0]    mx_in, my_in;
    logic [FRAC_BITS:0] dist_x, dist_y;
    logic [31:0]    prod_sat;
    logic [15:0]    tile_x_full, tile_y_full;
    logic           outside;
    logic           go_x, edge_x, edge_y;
    logic [32:0]    icx_add, icy_add;
    logic [31:0]    icx_sat, icy_sat;
    logic           mem_we, mem_wd;
    logic [AW-1:0]  mem_wa, rd_addr;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign vw_eff = (vw_reg == 8'd0) ? 8'd1 : vw_reg;
    assign vh_eff = (vh_reg == 8'd0) ? 8'd1 : vh_reg;

    // two's complement magnitude, the most negative code gives 32768
    assign mx_in = in_data.dir_x[15] ? 16'(17'h10000 - {1'b0, in_data.dir_x}) : in_data.dir_x;
    assign my_in = in_data.dir_y[15] ? 16'(17'h10000 - {1'b0, in_data.dir_y}) : in_data.dir_y;

    // one restoring divide step, a zero divisor gives all ones
    assign div_rem2 = {drem_reg, dq_reg[DW-1]};
    assign div_ge   = div_rem2 >= {1'b0, dvs_reg};
    assign div_diff = div_rem2 - {1'b0, dvs_reg};
    assign dq_ext   = 64'(dq_reg);
    assign q_sat    = (dq_ext[63:32] != 32'd0) ? SAT32 : dq_ext[31:0];
    assign len_ext  = (64'(root_reg) << FRAC_BITS) >> 16;

    // one root digit per cycle, low half of the radicand is zero
    assign s_rem2  = {srem_reg, sq_reg[31:30]};
    assign s_trial = {3'b000, root_reg, 2'b01};
    assign s_ge    = s_rem2 >= s_trial;

    assign dist_x = negx_reg ? {1'b0, px_reg[FRAC_BITS-1:0]}
                             : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, px_reg[FRAC_BITS-1:0]});
    assign dist_y = negy_reg ? {1'b0, py_reg[FRAC_BITS-1:0]}
                             : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, py_reg[FRAC_BITS-1:0]});
    assign prod_sat = prod_reg[FRAC_BITS+32] ? SAT32 : prod_reg[FRAC_BITS+31:FRAC_BITS];

    assign tile_x_full = px_reg[PW-1:FRAC_BITS];
    assign tile_y_full = py_reg[PW-1:FRAC_BITS];
    assign outside     = (int'(tile_x_full) >= GRID_W) || (int'(tile_y_full) >= GRID_H);

    // ties go to y
    assign go_x    = icx_reg < icy_reg;
    assign icx_add = {1'b0, icx_reg} + {1'b0, stepx_reg};
    assign icy_add = {1'b0, icy_reg} + {1'b0, stepy_reg};
    assign icx_sat = icx_add[32] ? SAT32 : icx_add[31:0];
    assign icy_sat = icy_add[32] ? SAT32 : icy_add[31:0];
    assign edge_x  = negx_reg ? (tx_reg == '0) : (tx_reg == XW'(GRID_W - 1));
    assign edge_y  = negy_reg ? (ty_reg == '0) : (ty_reg == YW'(GRID_H - 1));

    assign rd_addr = AW'(ty_reg) * AW'(GRID_W) + AW'(tx_reg);

    always_comb
    begin
        mem_we = 1'b0;
        mem_wd = 1'b0;
        mem_wa = clr_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (in_acc && in_data.mode == MODE_WRITE
                 && int'(in_data.cell_x) < GRID_W && int'(in_data.cell_y) < GRID_H)
        begin
            mem_we = 1'b1;
            mem_wd = in_data.cell_value > 8'sd0;
            mem_wa = AW'(in_data.cell_y) * AW'(GRID_W) + AW'(in_data.cell_x);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            map_rd_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (clr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:    if (in_acc && in_data.mode == MODE_RAY) state_next = ST_DIV_PX;
            ST_DIV_PX:  if (cnt_reg == '0) state_next = ST_DIV_PY;
            ST_DIV_PY:  if (cnt_reg == '0) state_next = ST_SQRT;
            ST_SQRT:    if (cnt_reg == '0) state_next = ST_DIV_SX;
            ST_DIV_SX:  if (cnt_reg == '0) state_next = ST_DIV_SY;
            ST_DIV_SY:  if (cnt_reg == '0) state_next = ST_MUL_X;
            ST_MUL_X:   state_next = ST_MUL_Y;
            ST_MUL_Y:   state_next = ST_MUL_END;
            ST_MUL_END: state_next = outside ? ST_DONE : ST_READ;
            ST_READ:    state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (map_rd_reg || (go_x ? edge_x : edge_y))
                    state_next = ST_DONE;
                else
                    state_next = ST_READ;
            end
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            vw_reg        <= VOXEL_RESET;
            vh_reg        <= VOXEL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AW'(1);

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_VOXEL_W)
                    vw_reg <= cfg_data;
                else
                    vh_reg <= cfg_data;
            end

            case (state_reg)
                ST_IDLE:   cnt_reg <= CW'(DW);
                ST_DIV_PX: cnt_reg <= (cnt_reg == '0) ? CW'(DW) : cnt_reg - CW'(1);
                ST_DIV_PY: cnt_reg <= (cnt_reg == '0) ? CW'(32) : cnt_reg - CW'(1);
                ST_SQRT:   cnt_reg <= (cnt_reg == '0) ? CW'(DW) : cnt_reg - CW'(1);
                ST_DIV_SX: cnt_reg <= (cnt_reg == '0) ? CW'(DW) : cnt_reg - CW'(1);
                ST_DIV_SY: cnt_reg <= (cnt_reg == '0) ? '0 : cnt_reg - CW'(1);
                default:   cnt_reg <= cnt_reg;
            endcase

            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
            out_reg <= res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    oy_reg   <= in_data.origin_y;
                    mx_reg   <= mx_in;
                    my_reg   <= my_in;
                    negx_reg <= in_data.dir_x[15];
                    negy_reg <= in_data.dir_y[15];
                    dq_reg   <= {in_data.origin_x, {FRAC_BITS{1'b0}}};
                    dvs_reg  <= {vw_eff, 8'd0};
                    drem_reg <= '0;
                end
            end
            ST_DIV_PX, ST_DIV_PY, ST_DIV_SX, ST_DIV_SY:
            begin
                if (cnt_reg != '0)
                begin
                    drem_reg <= div_ge ? div_diff[15:0] : div_rem2[15:0];
                    dq_reg   <= {dq_reg[DW-2:0], div_ge};
                end
                else
                begin
                    drem_reg <= '0;
                    case (state_reg)
                        ST_DIV_PX:
                        begin
                            px_reg  <= dq_reg[PW-1:0];
                            dq_reg  <= {oy_reg, {FRAC_BITS{1'b0}}};
                            dvs_reg <= {vh_eff, 8'd0};
                        end
                        ST_DIV_PY:
                        begin
                            py_reg   <= dq_reg[PW-1:0];
                            sq_reg   <= 32'(mx_reg) * 32'(mx_reg) + 32'(my_reg) * 32'(my_reg);
                            srem_reg <= '0;
                            root_reg <= '0;
                        end
                        ST_DIV_SX:
                        begin
                            stepx_reg <= q_sat;
                            dq_reg    <= len_ext[DW-1:0];
                            dvs_reg   <= my_reg;
                        end
                        default:
                        begin
                            stepy_reg <= q_sat;
                        end
                    endcase
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg != '0)
                begin
                    srem_reg <= s_ge ? 35'(s_rem2 - s_trial) : 35'(s_rem2);
                    root_reg <= {root_reg[30:0], s_ge};
                    sq_reg   <= {sq_reg[29:0], 2'b00};
                end
                else
                begin
                    dq_reg   <= len_ext[DW-1:0];
                    dvs_reg  <= mx_reg;
                    drem_reg <= '0;
                end
            end
            ST_MUL_X:
            begin
                prod_reg <= MW'(dist_x) * MW'(stepx_reg);
            end
            ST_MUL_Y:
            begin
                icx_reg  <= prod_sat;
                prod_reg <= MW'(dist_y) * MW'(stepy_reg);
            end
            ST_MUL_END:
            begin
                icy_reg   <= prod_sat;
                tx_reg    <= XW'(tile_x_full);
                ty_reg    <= YW'(tile_y_full);
                side_reg  <= 1'b0;
                first_reg <= 1'b1;
                res_reg   <= '{hit_x: 6'd0, hit_y: 6'd0, hit_side: 1'b0,
                               started_in_solid: 1'b0, left_grid: 1'b1};
            end
            ST_CHECK:
            begin
                if (map_rd_reg)
                begin
                    res_reg <= '{hit_x: 6'(tx_reg), hit_y: 6'(ty_reg), hit_side: side_reg,
                                 started_in_solid: first_reg, left_grid: 1'b0};
                end
                else
                begin
                    first_reg <= 1'b0;
                    side_reg  <= !go_x;
                    if (go_x)
                    begin
                        icx_reg <= icx_sat;
                        if (!edge_x)
                            tx_reg <= negx_reg ? tx_reg - XW'(1) : tx_reg + XW'(1);
                    end
                    else
                    begin
                        icy_reg <= icy_sat;
                        if (!edge_y)
                            ty_reg <= negy_reg ? ty_reg - YW'(1) : ty_reg + YW'(1);
                    end
                    // leaving the map keeps the last tile inside
                    res_reg <= '{hit_x: 6'(tx_reg), hit_y: 6'(ty_reg), hit_side: !go_x,
                                 started_in_solid: 1'b0, left_grid: 1'b1};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- tb/sv/tb_grid_ray_traversal_dda_core.sv -----
// ----------------------------------------------------------------------------
// tb_grid_ray_traversal_dda_core
// self-checking bench for the grid ray traversal core: map writes and ray
// casts are driven in bursts, each ray's outcome is predicted from a local
// copy of the tile map and voxel size, and results are matched in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import grdda_pkg::*;

class ray_scoreboard;
    bit          solid [64*64];
    logic [7:0]  vox_w;
    logic [7:0]  vox_h;
    out_word_t   exp_q[$];
    int          errors;
    int          n_rays;
    int          n_writes;
    int          n_hits;
    int          n_left;
    int          n_started;

    function new();
        vox_w = VOXEL_RESET;
        vox_h = VOXEL_RESET;
    endfunction

    function void set_voxel(logic idx, logic [7:0] val);
        if (idx == REG_VOXEL_W)
            vox_w = val;
        else
            vox_h = val;
    endfunction

    function longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function logic [31:0] axis_step(longint unsigned len, longint unsigned mag);
        longint unsigned q;
        if (mag == 0)
            return SAT32;
        q = (len << 16) / (mag << 16);
        return (q > 64'hFFFF_FFFF) ? SAT32 : q[31:0];
    endfunction

    function logic [31:0] first_cross(longint unsigned pos, bit neg, logic [31:0] st);
        longint unsigned frac;
        longint unsigned gap;
        longint unsigned p;
        frac = pos & 64'hFFFF;
        gap = neg ? frac : 64'h10000 - frac;
        p = (gap * st) >> 16;
        return (p > 64'hFFFF_FFFF) ? SAT32 : p[31:0];
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = a + b;
        return s[32] ? SAT32 : s[31:0];
    endfunction

    // work out the result of one accepted word
    function void note_input(in_word_t w);
        longint unsigned vw, vh, px, py, tx, ty, mx, my, len;
        logic [31:0] sx, sy, ix, iy;
        bit          negx, negy, first;
        out_word_t   r;
        if (w.mode == MODE_WRITE)
        begin
            n_writes++;
            solid[{w.cell_y, w.cell_x}] = (w.cell_value > 0);
            return;
        end
        n_rays++;
        vw = (vox_w == 0) ? 1 : vox_w;
        vh = (vox_h == 0) ? 1 : vox_h;
        px = ({40'd0, w.origin_x} << 16) / (vw << 8);
        py = ({40'd0, w.origin_y} << 16) / (vh << 8);
        tx = px >> 16;
        ty = py >> 16;
        negx = w.dir_x[15];
        negy = w.dir_y[15];
        mx = negx ? 64'h10000 - {48'd0, w.dir_x} : {48'd0, w.dir_x};
        my = negy ? 64'h10000 - {48'd0, w.dir_y} : {48'd0, w.dir_y};
        len = int_root((mx * mx + my * my) << 32);
        sx = axis_step(len, mx);
        sy = axis_step(len, my);
        ix = first_cross(px, negx, sx);
        iy = first_cross(py, negy, sy);
        r = '0;
        if (tx >= 64 || ty >= 64)
        begin
            r.left_grid = 1'b1;
            n_left++;
            exp_q.push_back(r);
            return;
        end
        first = 1;
        forever
        begin
            if (solid[ty * 64 + tx])
            begin
                if (first)
                    r.started_in_solid = 1'b1;
                break;
            end
            first = 0;
            if (ix < iy)
            begin
                r.hit_side = 1'b0;
                ix = sat_add(ix, sx);
                if (negx ? tx == 0 : tx + 1 >= 64)
                begin
                    r.left_grid = 1'b1;
                    break;
                end
                tx = negx ? tx - 1 : tx + 1;
            end
            else
            begin
                r.hit_side = 1'b1;
                iy = sat_add(iy, sy);
                if (negy ? ty == 0 : ty + 1 >= 64)
                begin
                    r.left_grid = 1'b1;
                    break;
                end
                ty = negy ? ty - 1 : ty + 1;
            end
        end
        r.hit_x = tx[5:0];
        r.hit_y = ty[5:0];
        if (r.left_grid)
            n_left++;
        else if (r.started_in_solid)
            n_started++;
        else
            n_hits++;
        exp_q.push_back(r);
    endfunction

    function void check_result(out_word_t got);
        out_word_t e;
        if (exp_q.size() == 0)
        begin
            $display("%0t: unexpected result word %p", $time, got);
            errors++;
            return;
        end
        e = exp_q.pop_front();
        if (got.hit_x !== e.hit_x)
            $display("%0t: hit_x expected %0d actual %0d", $time, e.hit_x, got.hit_x);
        if (got.hit_y !== e.hit_y)
            $display("%0t: hit_y expected %0d actual %0d", $time, e.hit_y, got.hit_y);
        if (got.hit_side !== e.hit_side)
            $display("%0t: hit_side expected %0b actual %0b", $time, e.hit_side,
                     got.hit_side);
        if (got.started_in_solid !== e.started_in_solid)
            $display("%0t: started_in_solid expected %0b actual %0b", $time,
                     e.started_in_solid, got.started_in_solid);
        if (got.left_grid !== e.left_grid)
            $display("%0t: left_grid expected %0b actual %0b", $time, e.left_grid,
                     got.left_grid);
        if (got !== e)
            errors++;
    endfunction
endclass

module tb_grid_ray_traversal_dda_core;

    localparam int IDLE_LIMIT = 20000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_word_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_word_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = REG_VOXEL_W;
    logic [7:0] cfg_data = '0;

    ray_scoreboard sb = new();
    int  burst_left;
    int  idle_cycles;
    int  cyc;

    grid_ray_traversal_dda_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // result side checks and watchdog
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_result(out_data);
        if ((out_valid && !out_stall) || (in_valid && !in_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall pattern: free, random, then long stretches
    always @(negedge clk)
    begin
        cyc <= cyc + 1;
        case ((cyc / 700) % 3)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 40);
            default: out_stall <= ((cyc % 37) < 20);
        endcase
    end

    task automatic write_reg(logic idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_voxel(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(in_word_t w);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(w);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.exp_q.size() != 0)
            @(posedge clk);
        // a trailing map write gives no result word, so the queue does not track it
        repeat (20) @(posedge clk);
    endtask

    function automatic in_word_t cell_word(int x, int y, int v);
        in_word_t w;
        w = '0;
        w.mode = MODE_WRITE;
        w.cell_x = 6'(x);
        w.cell_y = 6'(y);
        w.cell_value = 8'(v);
        return w;
    endfunction

    function automatic in_word_t ray_word(int ox, int oy, int dx, int dy);
        in_word_t w;
        w = '0;
        w.mode = MODE_RAY;
        w.origin_x = 24'(ox);
        w.origin_y = 24'(oy);
        w.dir_x = 16'(dx);
        w.dir_y = 16'(dy);
        return w;
    endfunction

    // in-map world coordinate for the current voxel size
    function automatic int world_pos(logic [7:0] vox);
        int span;
        span = ((vox == 0) ? 1 : vox) * 256;
        return $urandom_range(0, 63) * span + $urandom_range(0, span - 1);
    endfunction

    task automatic random_phase(int count, int density);
        in_word_t w;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                w = cell_word($urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 255));
                if ($urandom_range(0, 99) < density)
                    w.cell_value = 8'($urandom_range(1, 127));
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                w = ray_word($urandom(), $urandom(),
                             $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
            else
            begin
                w = ray_word(world_pos(sb.vox_w), world_pos(sb.vox_h),
                             $urandom_range(0, 65535), $urandom_range(0, 65535));
                if ($urandom_range(0, 9) == 0)
                    w.dir_x = '0;
                else if ($urandom_range(0, 9) == 0)
                    w.dir_y = '0;
            end
            send_word(w);
        end
    endtask

    initial
    begin
        idle_cycles = 0;
        cyc = 0;
        burst_left = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset voxel size, extreme cells and directions
        send_word(cell_word(0, 0, 127));
        send_word(cell_word(63, 63, 1));
        send_word(cell_word(63, 0, -128));
        send_word(cell_word(0, 63, 0));
        send_word(ray_word(100, 100, 256, 0));
        send_word(ray_word(16 * 256 * 10, 16 * 256 * 10, -32768, -32768));
        send_word(ray_word(24'hFFFFFF, 24'hFFFFFF, 256, 256));
        send_word(ray_word(16 * 256 * 5, 24'hFFFFFF, 0, 256));
        send_word(ray_word(16 * 256 * 20 + 7, 16 * 256 * 30, 0, 0));
        send_word(ray_word(16 * 256 * 62, 16 * 256 * 62, 32767, 32767));
        send_word(ray_word(16 * 256 * 3, 16 * 256 * 3, 0, -1));
        send_word(ray_word(16 * 256 * 40, 16 * 256 * 1, 1, -32768));
        send_word(cell_word(5, 5, 1));
        send_word(ray_word(16 * 256 * 5 + 1, 16 * 256 * 5 + 1, -300, 700));
        send_word(ray_word(16 * 256 * 2, 16 * 256 * 5 + 128, 256, 0));
        send_word(cell_word(5, 5, -1));
        send_word(ray_word(16 * 256 * 2, 16 * 256 * 5 + 128, 256, 0));
        drain();

        write_reg(REG_VOXEL_W, 8'd1);
        write_reg(REG_VOXEL_H, 8'd1);
        random_phase(220, 30);
        // hold off until everything is back, then carry on at the same size
        @(negedge clk);
        in_valid <= 1'b0;
        drain();
        random_phase(40, 50);
        drain();

        write_reg(REG_VOXEL_W, 8'd255);
        write_reg(REG_VOXEL_H, 8'd255);
        random_phase(220, 60);
        drain();

        write_reg(REG_VOXEL_W, 8'd0);
        write_reg(REG_VOXEL_H, 8'd200);
        random_phase(165, 15);
        drain();

        write_reg(REG_VOXEL_W, 8'd7);
        write_reg(REG_VOXEL_H, 8'd0);
        random_phase(165, 40);
        drain();

        write_reg(REG_VOXEL_W, 8'($urandom_range(1, 255)));
        write_reg(REG_VOXEL_H, 8'($urandom_range(1, 255)));
        random_phase(165, 80);
        drain();

        write_reg(REG_VOXEL_W, VOXEL_RESET);
        write_reg(REG_VOXEL_H, VOXEL_RESET);
        random_phase(165, 5);
        @(negedge clk);
        in_valid <= 1'b0;
        drain();
        repeat (600) @(posedge clk);

        $display("covered %0d rays and %0d map writes over seven voxel sizes",
                 sb.n_rays, sb.n_writes);
        $display("rays hitting a wall %0d, starting in solid %0d, leaving the map %0d",
                 sb.n_hits, sb.n_started, sb.n_left);
        if (sb.errors == 0 && sb.exp_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
